[sv/mgq_pkg.sv]
// ----------------------------------------------------------------------------
// mgq_pkg: shared definitions for the min/max gray quantizer
// Default sizes, item command codes and the control/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mgq_pkg;

  // Default sizes
  localparam int unsigned MAX_PIXELS_DEF  = 524288;
  localparam int unsigned SAMPLE_BITS_DEF = 24;
  localparam int unsigned LEVELS_DEF      = 256;

  // Width of the gray level port
  localparam int unsigned GRAY_W = 8;

  // Item command codes
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_FETCH = 1'b1
  } mgq_op_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_en;   // load transaction accepted this cycle
    logic fetch_en;  // fetch transaction accepted this cycle
    logic setup_en;  // store read data is ready, prime the divider
    logic div_en;    // one quotient bit per cycle
    logic res_en;    // write the output register
  } mgq_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;     // read pointer has caught up with the pixel count
  } mgq_stat_t;

endpackage

[sv/mgq_ctrl.sv]
// ----------------------------------------------------------------------------
// mgq_ctrl: controller of the min/max gray quantizer
// Sequences one fetch at a time through store read, then, if a pixel is left, divider
// setup and the bit-serial divide, and output register; loads complete on acceptance.
// ----------------------------------------------------------------------------
module mgq_ctrl
  import mgq_pkg::*;
#(
  parameter int unsigned LevelBits = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_cmd_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mgq_ctrl_t ctrl_o,
  input  mgq_stat_t stat_i
);

  localparam int unsigned StepBits = $clog2(LevelBits + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  state_e               state_q;
  logic [StepBits-1:0]  step_q;
  logic                 out_valid_q;
  logic                 accept;

  // Command decode
  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    accept          = in_valid_i & in_ready_o;
    ctrl_o.load_en  = accept && (in_cmd_i == CMD_LOAD);
    ctrl_o.fetch_en = accept && (in_cmd_i == CMD_FETCH);
    ctrl_o.setup_en = (state_q == ST_SETUP);
    ctrl_o.div_en   = (state_q == ST_DIVIDE);
    ctrl_o.res_en   = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  end

  assign out_valid_o = out_valid_q;

  // State, step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (ctrl_o.fetch_en) begin
            state_q <= stat_i.empty ? ST_FINISH : ST_SETUP;
          end
        end
        ST_SETUP: begin
          state_q <= ST_DIVIDE;
          step_q  <= StepBits'(LevelBits - 1);
        end
        ST_DIVIDE: begin
          if (step_q == '0) begin
            state_q <= ST_FINISH;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        ST_FINISH: begin
          if (ctrl_o.res_en) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (ctrl_o.res_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // A fetch with a pixel to read passes through setup and the divide to the output stage
  a_fetch_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.fetch_en && !stat_i.empty) |-> ##(LevelBits + 2) (state_q == ST_FINISH))
    else $error("fetch did not reach output stage on time");
`endif

endmodule

[sv/mgq_datapath.sv]
// ----------------------------------------------------------------------------
// mgq_datapath: store, counters, min/max tracking and level divider
// Holds the frame store, pixel count, read pointer and running min/max,
// and computes each level with a restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module mgq_datapath
  import mgq_pkg::*;
#(
  parameter int unsigned MaxPixels  = MAX_PIXELS_DEF,
  parameter int unsigned SampleBits = SAMPLE_BITS_DEF,
  parameter int unsigned Levels     = LEVELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mgq_ctrl_t                    ctrl_i,
  output mgq_stat_t                    stat_o,
  input  logic                         new_frame_i,
  input  logic signed [SampleBits-1:0] sample_i,
  output logic        [GRAY_W-1:0]     gray_level_o,
  output logic                         last_o,
  output logic                         error_o
);

  localparam int unsigned LevelBits = $clog2(Levels);
  localparam int unsigned AddrBits  = (MaxPixels > 1) ? $clog2(MaxPixels) : 1;
  localparam int unsigned CntBits   = $clog2(MaxPixels + 1);
  localparam int unsigned NumBits   = SampleBits + LevelBits;

  localparam logic signed [SampleBits-1:0] MostPos = {1'b0, {(SampleBits-1){1'b1}}};
  localparam logic signed [SampleBits-1:0] MostNeg = {1'b1, {(SampleBits-1){1'b0}}};

  // Frame store
  logic [SampleBits-1:0] pixel_store_q [MaxPixels];

  // Control state
  logic        [CntBits-1:0]    cnt_q, cnt_d;
  logic        [CntBits-1:0]    ptr_q, ptr_d;
  logic signed [SampleBits-1:0] min_q, min_d;
  logic signed [SampleBits-1:0] max_q, max_d;

  // Fetch and divider payload
  logic signed [SampleBits-1:0] rd_data_q;
  logic                         last_pend_q, err_pend_q;
  logic                         flat_q, flat_d;
  logic        [NumBits-1:0]    rem_q, rem_d;
  logic        [NumBits-1:0]    div_q, div_d;
  logic        [LevelBits-1:0]  quo_q, quo_d;
  logic        [GRAY_W-1:0]     gray_q;
  logic                         last_q, err_q;

  // Load path signals
  logic        [CntBits-1:0]    eff_cnt;
  logic signed [SampleBits-1:0] eff_min, eff_max;
  logic                         store_we;

  // Setup signals
  logic signed [SampleBits:0]   dist_w, range_w;
  logic        [NumBits-1:0]    num;

  assign stat_o.empty = (ptr_q >= cnt_q);

  // Load: optional frame clear; if room, append sample and widen min/max
  always_comb begin
    eff_cnt  = new_frame_i ? '0 : cnt_q;
    eff_min  = new_frame_i ? MostPos : min_q;
    eff_max  = new_frame_i ? MostNeg : max_q;
    store_we = ctrl_i.load_en && (eff_cnt < CntBits'(MaxPixels));

    cnt_d = cnt_q;
    ptr_d = ptr_q;
    min_d = min_q;
    max_d = max_q;
    if (ctrl_i.load_en) begin
      if (new_frame_i) begin
        cnt_d = '0;
        ptr_d = '0;
        min_d = MostPos;
        max_d = MostNeg;
      end
      if (store_we) begin
        cnt_d = eff_cnt + 1'b1;
        min_d = (sample_i < eff_min) ? sample_i : eff_min;
        max_d = (sample_i > eff_max) ? sample_i : eff_max;
      end
    end else if (ctrl_i.fetch_en && !stat_o.empty) begin
      ptr_d = ptr_q + 1'b1;
    end
  end

  // Divider: level = floor((dist*Levels - 1) / range)
  always_comb begin
    dist_w  = {rd_data_q[SampleBits-1], rd_data_q} - {min_q[SampleBits-1], min_q};
    range_w = {max_q[SampleBits-1], max_q} - {min_q[SampleBits-1], min_q};
    num     = NumBits'(dist_w[SampleBits-1:0]) * NumBits'(Levels);

    flat_d = flat_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (ctrl_i.setup_en) begin
      flat_d = (max_q <= min_q) || (rd_data_q <= min_q);
      rem_d  = num - 1'b1;
      div_d  = NumBits'(range_w[SampleBits-1:0]) << (LevelBits - 1);
      quo_d  = '0;
    end else if (ctrl_i.div_en) begin
      if (rem_q >= div_q) begin
        rem_d = rem_q - div_q;
        quo_d = (quo_q << 1) | LevelBits'(1);
      end else begin
        quo_d = quo_q << 1;
      end
      div_d = div_q >> 1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
      min_q <= MostPos;
      max_q <= MostNeg;
    end else begin
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  // Store write port
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      pixel_store_q[eff_cnt[AddrBits-1:0]] <= sample_i;
    end
  end

  // Store read port, registered
  always_ff @(posedge clk_i) begin
    if (ctrl_i.fetch_en) begin
      rd_data_q <= pixel_store_q[ptr_q[AddrBits-1:0]];
    end
  end

  // Fetch flags, divider and output registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.fetch_en) begin
      err_pend_q  <= stat_o.empty;
      last_pend_q <= (ptr_q + 1'b1 == cnt_q);
    end
    flat_q <= flat_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    quo_q  <= quo_d;
    if (ctrl_i.res_en) begin
      gray_q <= (err_pend_q || flat_q) ? '0 : GRAY_W'(quo_q);
      last_q <= !err_pend_q && last_pend_q;
      err_q  <= err_pend_q;
    end
  end

  assign gray_level_o = gray_q;
  assign last_o       = last_q;
  assign error_o      = err_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(MaxPixels))
    else $error("pixel count beyond store depth");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= cnt_q)
    else $error("read pointer passed pixel count");

  a_minmax_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (min_q <= max_q))
    else $error("min above max in a non-empty frame");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.res_en |=> (gray_q <= GRAY_W'(Levels - 1)))
    else $error("gray level out of range");
`endif

endmodule

[sv/minmax_gray_quantizer.sv]
// ----------------------------------------------------------------------------
// minmax_gray_quantizer: min-max normalization of a frame to gray levels
// Loads signed Q8.16 samples into a frame store while tracking min and max,
// then returns one gray level per stored sample, in load order, per fetch.
// ----------------------------------------------------------------------------
// A load transaction completes in the cycle it is accepted, so loads stream
// at one per cycle while no fetch is in flight. A fetch with a pixel to read
// holds the input through the acceptance cycle with the registered store
// read, a setup step to form the distance and range, the restoring divider
// at one quotient bit per cycle, and a final step to write the output
// register, which then holds its result. A fetch that finds no pixel left
// skips the divider. The block takes no new transaction while a fetch is
// in flight, and a fetch waits in its last cycle for as long as the output
// register still holds an unaccepted result. A finished result may wait in
// the output register while loads continue. The store has no clearing pass
// after reset; only entries written in the current frame are ever used for
// a result.
module minmax_gray_quantizer
  import mgq_pkg::*;
#(
  parameter int unsigned MaxPixels  = MAX_PIXELS_DEF,
  parameter int unsigned SampleBits = SAMPLE_BITS_DEF,
  parameter int unsigned Levels     = LEVELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         cmd_i,
  input  logic                         new_frame_i,
  input  logic signed [SampleBits-1:0] sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic        [GRAY_W-1:0]     gray_level_o,
  output logic                         last_o,
  output logic                         error_o
);

  localparam int unsigned LevelBits = $clog2(Levels);

  mgq_ctrl_t ctrl;
  mgq_stat_t stat;

  // Controller
  mgq_ctrl #(
    .LevelBits (LevelBits)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (cmd_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl),
    .stat_i      (stat)
  );

  // Datapath
  mgq_datapath #(
    .MaxPixels  (MaxPixels),
    .SampleBits (SampleBits),
    .Levels     (Levels)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .new_frame_i  (new_frame_i),
    .sample_i     (sample_i),
    .gray_level_o (gray_level_o),
    .last_o       (last_o),
    .error_o      (error_o)
  );

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for minmax_gray_quantizer
// Drives load and fetch transactions with random gaps and back-pressure.
// A scoreboard object mirrors the frame store and its min/max, computes
// each fetched gray level exactly in integers and compares every result
// field against the oldest pending level.
// ----------------------------------------------------------------------------
import mgq_pkg::*;

typedef struct {
  logic [GRAY_W-1:0] gray;
  logic              last;
  logic              err;
} gray_result_t;

// Mirror of the frame store plus the queue of levels still owed by the block
class gray_level_board;
  logic signed [SAMPLE_BITS_DEF-1:0] frame_store [MAX_PIXELS_DEF];
  int unsigned  stored;
  int unsigned  read_idx;
  longint       lo_seen;
  longint       hi_seen;
  gray_result_t pending_levels [$];
  int           errors;

  function new();
    errors = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    stored   = 0;
    read_idx = 0;
    lo_seen  = (longint'(1) <<< (SAMPLE_BITS_DEF - 1)) - 1;
    hi_seen  = -(longint'(1) <<< (SAMPLE_BITS_DEF - 1));
  endfunction

  // Smallest level whose upper threshold covers the sample, exact compare
  function logic [GRAY_W-1:0] level_of(longint s);
    longint unsigned span;
    longint unsigned offs;
    longint unsigned num;
    longint unsigned q;
    if (hi_seen <= lo_seen || s <= lo_seen) return '0;
    span = longint'(hi_seen - lo_seen);
    offs = longint'(s - lo_seen);
    num  = offs * LEVELS_DEF;
    q    = num / span;
    if (num % span != 0) q++;
    if (q == 0) return '0;
    q--;
    if (q > LEVELS_DEF - 1) q = LEVELS_DEF - 1;
    return q[GRAY_W-1:0];
  endfunction

  // Called for every accepted input transaction
  function void note_item(mgq_op_e op, logic nf, logic signed [SAMPLE_BITS_DEF-1:0] s);
    gray_result_t r;
    longint       v;
    v = s;
    if (op == CMD_LOAD) begin
      if (nf) clear_frame();
      if (stored >= MAX_PIXELS_DEF) return;  // store full: dropped
      frame_store[stored] = s;
      stored++;
      if (v < lo_seen) lo_seen = v;
      if (v > hi_seen) hi_seen = v;
    end else begin
      if (read_idx >= stored) begin
        r.gray = '0;
        r.last = 1'b0;
        r.err  = 1'b1;
      end else begin
        r.gray = level_of(frame_store[read_idx]);
        r.last = (read_idx + 1 == stored);
        r.err  = 1'b0;
        read_idx++;
      end
      pending_levels.insert(pending_levels.size(), r);
    end
  endfunction

  function int pending();
    return pending_levels.size();
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 50) $display("mismatch: %s", msg);
  endtask

  // Called for every accepted result transaction
  task check_level(logic [GRAY_W-1:0] gray, logic last, logic err);
    gray_result_t want;
    if (pending_levels.size() == 0) begin
      report($sformatf("result with nothing pending: gray=%0d last=%0b err=%0b",
                       gray, last, err));
      return;
    end
    want = pending_levels.pop_front();
    if (gray !== want.gray)
      report($sformatf("gray_level got %0d want %0d", gray, want.gray));
    if (last !== want.last)
      report($sformatf("last got %0b want %0b", last, want.last));
    if (err !== want.err)
      report($sformatf("error got %0b want %0b", err, want.err));
  endtask
endclass

module testbench;

  localparam int RANDOM_ITEMS  = 1850;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 30;
  localparam int IDLE_PCT      = 10;
  localparam logic signed [SAMPLE_BITS_DEF-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS_DEF-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS_DEF-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS_DEF-1){1'b0}}};

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid;
  logic                               in_ready;
  logic                               cmd_d;
  logic                               new_frame_d;
  logic signed [SAMPLE_BITS_DEF-1:0]  sample_d;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic        [GRAY_W-1:0]           gray_level;
  logic                               last;
  logic                               error;

  // Values sampled at the falling edge, used at the next rising edge
  bit                                 in_fire;
  bit                                 out_fire;
  mgq_op_e                            mon_cmd;
  logic                               mon_nf;
  logic signed [SAMPLE_BITS_DEF-1:0]  mon_sample;
  logic        [GRAY_W-1:0]           mon_gray;
  logic                               mon_last;
  logic                               mon_err;

  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_req;
  logic        hold_ack = 1'b0;
  int          hold_left = 0;
  int          stall_cycles = 0;
  int          items_sent;

  gray_level_board board;

  minmax_gray_quantizer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .cmd_i        (cmd_d),
    .new_frame_i  (new_frame_d),
    .sample_i     (sample_d),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .gray_level_o (gray_level),
    .last_o       (last),
    .error_o      (error)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Sample handshakes and payloads mid-cycle, clear of edge races
  always @(negedge clk_i) begin
    in_fire    = in_valid && in_ready;
    out_fire   = out_valid && out_ready;
    mon_cmd    = mgq_op_e'(cmd_d);
    mon_nf     = new_frame_d;
    mon_sample = sample_d;
    mon_gray   = gray_level;
    mon_last   = last;
    mon_err    = error;
  end

  // Scoreboard updates and watchdog
  always @(posedge clk_i) begin
    if (in_fire) board.note_item(mon_cmd, mon_nf, mon_sample);
    if (out_fire) board.check_level(mon_gray, mon_last, mon_err);
    if (in_fire || out_fire) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Result side: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // One input transaction, with an optional gap before it
  task automatic send_item(input mgq_op_e op, input logic nf,
                           input logic signed [SAMPLE_BITS_DEF-1:0] s);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 2);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    cmd_d       <= op;
    new_frame_d <= nf;
    sample_d    <= s;
    do @(posedge clk_i); while (!in_fire);
    items_sent++;
  endtask

  // Sample generator: full range, a narrow band just above a center, or extremes, 0 and -1
  function automatic logic signed [SAMPLE_BITS_DEF-1:0] pick_sample(int mode, longint center);
    longint v;
    logic [SAMPLE_BITS_DEF-1:0] raw;
    raw = SAMPLE_BITS_DEF'($urandom);
    case (mode)
      1: begin
        v = center + $urandom_range(0, 40);
        if (v > longint'(SAMPLE_MAX)) v = SAMPLE_MAX;
        return v[SAMPLE_BITS_DEF-1:0];
      end
      2: begin
        case ($urandom_range(0, 4))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          3: return '1;
          default: return raw;
        endcase
      end
      default: return raw;
    endcase
  endfunction

  // One well-formed frame: loads, readout (maybe cut short) with appends, maybe extra fetches
  task automatic run_frame();
    int     n;
    int     mode;
    int     to_fetch;
    longint center;
    logic [SAMPLE_BITS_DEF-1:0] raw;
    bit     cut;
    n      = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 24);
    mode   = $urandom_range(0, 2);
    raw    = SAMPLE_BITS_DEF'($urandom);
    center = $signed(raw);
    cut    = ($urandom_range(0, 9) == 0);
    send_item(CMD_LOAD, 1'b1, pick_sample(mode, center));
    for (int k = 1; k < n; k++) send_item(CMD_LOAD, 1'b0, pick_sample(mode, center));
    to_fetch = n;
    while (to_fetch > 0) begin
      if (cut && $urandom_range(0, 3) == 0) break;
      send_item(CMD_FETCH, 1'($urandom_range(0, 1)), SAMPLE_BITS_DEF'($urandom));
      to_fetch--;
      if ($urandom_range(0, 19) == 0) begin
        send_item(CMD_LOAD, 1'b0, pick_sample($urandom_range(0, 2), center));
        to_fetch++;
      end
    end
    if (!cut && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 2))
        send_item(CMD_FETCH, 1'($urandom_range(0, 1)), SAMPLE_BITS_DEF'($urandom));
  endtask

  initial begin
    int base_items;
    int frame_no;
    board         = new();
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    cmd_d         = CMD_LOAD;
    new_frame_d   = 1'b0;
    sample_d      = '0;
    hold_req      = 1'b0;
    items_sent    = 0;
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty fetch, flat frame, extremes, append mid-readout, thresholds
    send_item(CMD_FETCH, 1'b0, '0);
    send_item(CMD_LOAD, 1'b1, 24'sd1234);
    send_item(CMD_LOAD, 1'b0, 24'sd1234);
    send_item(CMD_FETCH, 1'b0, '0);
    send_item(CMD_FETCH, 1'b0, '0);
    send_item(CMD_FETCH, 1'b0, '0);
    send_item(CMD_LOAD, 1'b1, SAMPLE_MIN);
    send_item(CMD_LOAD, 1'b0, SAMPLE_MAX);
    send_item(CMD_LOAD, 1'b0, '0);
    send_item(CMD_LOAD, 1'b0, '1);
    send_item(CMD_FETCH, 1'b1, SAMPLE_MAX);
    send_item(CMD_FETCH, 1'b0, '0);
    send_item(CMD_LOAD, 1'b0, 24'sh000100);
    send_item(CMD_FETCH, 1'b0, '0);
    send_item(CMD_FETCH, 1'b0, '0);
    send_item(CMD_FETCH, 1'b0, '0);
    send_item(CMD_FETCH, 1'b0, '0);
    send_item(CMD_LOAD, 1'b1, 24'sd100);
    send_item(CMD_LOAD, 1'b0, 24'sd356);
    send_item(CMD_LOAD, 1'b0, 24'sd101);
    send_item(CMD_LOAD, 1'b0, 24'sd355);
    send_item(CMD_FETCH, 1'b0, '0);
    send_item(CMD_FETCH, 1'b0, '0);
    send_item(CMD_FETCH, 1'b0, '0);
    send_item(CMD_FETCH, 1'b0, '0);

    // Random frames, with noise, one stretch with no random gaps or stalls and one long hold-off
    base_items = items_sent;
    frame_no   = 0;
    while (items_sent - base_items < RANDOM_ITEMS) begin
      if (frame_no == 20) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      if (frame_no == 40) begin
        send_idle_pct <= IDLE_PCT;
        recv_idle_pct <= IDLE_PCT;
      end
      if (frame_no == 60) hold_req <= ~hold_req;
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 12))
          send_item(mgq_op_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    SAMPLE_BITS_DEF'($urandom));
      else
        run_frame();
      frame_no++;
    end

    // Readout past the end, then a fresh single-pixel frame
    repeat (6) send_item(CMD_FETCH, 1'b0, '0);
    send_item(CMD_LOAD, 1'b1, 24'sd77);
    send_item(CMD_FETCH, 1'b0, '0);
    send_item(CMD_FETCH, 1'b0, '0);

    // Drain
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

[filelist.f]
sv/mgq_pkg.sv
sv/mgq_ctrl.sv
sv/mgq_datapath.sv
sv/minmax_gray_quantizer.sv
bench/testbench.sv
